// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the precondition holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/bmpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpu_pkg
// Shared types, codes and defaults of the bitmap row pixel unpacker.
// ----------------------------------------------------------------------------
package bmpu_pkg;

	localparam int MAX_WIDTH_DEFAULT     = 4096;
	localparam int PALETTE_DEPTH_DEFAULT = 256;
	localparam int CMD_QUEUE_DEPTH       = 4;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 13;
	localparam int TDATA_W     = 40;
	localparam int COL_OUT_W   = 12;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b1;

	// Pixel format codes
	localparam logic [2:0] FMT_1BPP   = 3'd0;
	localparam logic [2:0] FMT_2BPP   = 3'd1;
	localparam logic [2:0] FMT_4BPP   = 3'd2;
	localparam logic [2:0] FMT_8BPP   = 3'd3;
	localparam logic [2:0] FMT_16BPP  = 3'd4;
	localparam logic [2:0] FMT_24BPP  = 3'd5;
	localparam logic [2:0] FMT_32BPP  = 3'd6;
	localparam logic [2:0] FMT_UNSUP  = 3'd7;

	// Request kinds on the input stream
	localparam logic ACT_PALETTE = 1'b0;
	localparam logic ACT_PIXEL   = 1'b1;

	typedef enum logic [1:0] {
		CMD_PAL_WR  = 2'd0,
		CMD_INDEXED = 2'd1,
		CMD_DIRECT  = 2'd2,
		CMD_ERROR   = 2'd3
	} cmd_kind_t;

	// One entry of the command queue between front and back end.
	typedef struct packed {
		cmd_kind_t              kind;
		logic [7:0]             data;      // pixel byte or palette index
		logic [23:0]            rgb;       // palette value or direct colour
		logic [1:0]             log2bpp;   // indexed modes only
		logic [2:0]             count_m1;  // pixels in this byte minus one
		logic [COL_OUT_W-1:0]   col;       // column of the first pixel
		logic                   row_done;  // final pixel closes the row
	} cmd_t;

endpackage

// ===== rtl/bmpu_front.sv =====
// ----------------------------------------------------------------------------
// bmpu_front
// Accepts requests, holds the configuration and row state, and turns each
// request into at most one command for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmpu_front #(
	parameter int MAX_WIDTH = bmpu_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bmpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bmpu_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bmpu_pkg::TDATA_W-1:0]         s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 q_full,
	output logic                                 q_push,
	output bmpu_pkg::cmd_t                       q_cmd
);

	localparam int WMAX   = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
	localparam int COL_W  = $clog2(WMAX + 1);
	localparam int BITS_W = COL_W + 6;
	localparam int RL_W   = COL_W + 2;
	localparam int CMP_W  = (COL_W > 4) ? COL_W : 4;

	logic [2:0]                        fmt_q;
	logic [bmpu_pkg::CFG_DATA_W-1:0]   width_q;
	logic [COL_W-1:0]                  col_q;
	logic [RL_W-1:0]                   rbc_q;
	logic [1:0]                        bip_q;
	logic [15:0]                       partial_q;

	logic [bmpu_pkg::CFG_DATA_W-1:0]   w_wide;
	logic [COL_W-1:0]                  w_eff;
	logic [BITS_W-1:0]                 w_ext;
	logic [BITS_W-1:0]                 row_bits;
	logic [BITS_W-1:0]                 row_words;
	logic [RL_W-1:0]                   row_len;
	logic [RL_W:0]                     rbc_inc;
	logic                              restart;

	logic [7:0]                        byte_in;
	logic [3:0]                        per_byte;
	logic [COL_W-1:0]                  remaining;
	logic [CMP_W-1:0]                  rem_c;
	logic [CMP_W-1:0]                  pb_c;
	logic [3:0]                        n_idx;
	logic [15:0]                       c16;
	logic [23:0]                       rgb16;
	logic [23:0]                       rgb24;

	logic                              accept;
	logic                              step;
	logic                              push_want;
	logic                              emit;
	logic [COL_W-1:0]                  col_n;
	logic [1:0]                        bip_n;
	logic [15:0]                       part_n;

	assign byte_in  = s_tdata[39:32];
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && push_want;

	// Effective row width: zero counts as one, oversize is clamped.
	always_comb begin
		if (width_q == '0) begin
			w_wide = bmpu_pkg::CFG_DATA_W'(1);
		end else if (width_q > bmpu_pkg::CFG_DATA_W'(WMAX)) begin
			w_wide = bmpu_pkg::CFG_DATA_W'(WMAX);
		end else begin
			w_wide = width_q;
		end
		w_eff = COL_W'(w_wide);
	end

	// Padded row length in bytes: bits rounded up to whole 32-bit words.
	always_comb begin
		w_ext = BITS_W'(w_eff);
		unique case (fmt_q)
			bmpu_pkg::FMT_1BPP:  row_bits = w_ext;
			bmpu_pkg::FMT_2BPP:  row_bits = w_ext << 1;
			bmpu_pkg::FMT_4BPP:  row_bits = w_ext << 2;
			bmpu_pkg::FMT_8BPP:  row_bits = w_ext << 3;
			bmpu_pkg::FMT_16BPP: row_bits = w_ext << 4;
			bmpu_pkg::FMT_24BPP: row_bits = (w_ext << 4) + (w_ext << 3);
			bmpu_pkg::FMT_32BPP: row_bits = w_ext << 5;
			bmpu_pkg::FMT_UNSUP: row_bits = w_ext << 5;
		endcase
		row_words = (row_bits + BITS_W'(31)) >> 5;
		row_len   = RL_W'(row_words << 2);
	end

	// Indexed modes: how many pixels this byte still holds for the row.
	always_comb begin
		per_byte  = 4'd8 >> fmt_q[1:0];
		remaining = w_eff - col_q;
		rem_c     = CMP_W'(remaining);
		pb_c      = CMP_W'(per_byte);
		n_idx     = (rem_c < pb_c) ? 4'(rem_c) : per_byte;
	end

	assign c16   = {byte_in, partial_q[7:0]};
	assign rgb16 = {c16[14:10], 3'b000, c16[9:5], 3'b000, c16[4:0], 3'b000};
	assign rgb24 = {byte_in, partial_q[15:8], partial_q[7:0]};

	always_comb begin
		q_cmd     = '0;
		push_want = 1'b0;
		step      = 1'b0;
		emit      = 1'b0;
		col_n     = col_q;
		bip_n     = bip_q;
		part_n    = partial_q;
		if (s_tuser == bmpu_pkg::ACT_PALETTE) begin
			q_cmd.kind = bmpu_pkg::CMD_PAL_WR;
			q_cmd.data = s_tdata[7:0];
			q_cmd.rgb  = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
			push_want  = 1'b1;
		end else if (fmt_q == bmpu_pkg::FMT_UNSUP) begin
			q_cmd.kind = bmpu_pkg::CMD_ERROR;
			push_want  = 1'b1;
		end else begin
			step = 1'b1;
			if (!fmt_q[2]) begin
				q_cmd.kind     = bmpu_pkg::CMD_INDEXED;
				q_cmd.data     = byte_in;
				q_cmd.log2bpp  = fmt_q[1:0];
				q_cmd.count_m1 = 3'(n_idx - 4'd1);
				q_cmd.col      = bmpu_pkg::COL_OUT_W'(col_q);
				q_cmd.row_done = (rem_c <= pb_c);
				push_want      = (n_idx != 4'd0);
				col_n          = col_q + COL_W'(n_idx);
			end else if (col_q != w_eff) begin
				q_cmd.kind     = bmpu_pkg::CMD_DIRECT;
				q_cmd.col      = bmpu_pkg::COL_OUT_W'(col_q);
				q_cmd.row_done = ((col_q + COL_W'(1)) == w_eff);
				q_cmd.rgb      = (fmt_q == bmpu_pkg::FMT_16BPP) ? rgb16 : rgb24;
				if (fmt_q == bmpu_pkg::FMT_16BPP) begin
					if (bip_q == 2'd0) begin
						part_n[7:0] = byte_in;
						bip_n       = 2'd1;
					end else begin
						emit  = 1'b1;
						bip_n = 2'd0;
					end
				end else begin
					unique case (bip_q)
						2'd0: begin
							part_n[7:0] = byte_in;
							bip_n       = 2'd1;
						end
						2'd1: begin
							part_n[15:8] = byte_in;
							bip_n        = 2'd2;
						end
						2'd2: begin
							emit  = 1'b1;
							bip_n = (fmt_q == bmpu_pkg::FMT_32BPP) ? 2'd3 : 2'd0;
						end
						2'd3: begin
							// Alpha byte of a 32-bit pixel is dropped.
							bip_n = 2'd0;
						end
					endcase
				end
				push_want = emit;
				if (emit) begin
					col_n = col_q + COL_W'(1);
				end
			end
		end
		rbc_inc = {1'b0, rbc_q} + (RL_W + 1)'(1);
		restart = (rbc_inc >= {1'b0, row_len});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= bmpu_pkg::FMT_24BPP;
			width_q <= bmpu_pkg::CFG_DATA_W'(1);
			col_q   <= '0;
			rbc_q   <= '0;
			bip_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmpu_pkg::REG_PIXEL_FORMAT: fmt_q   <= cfg_data[2:0];
				bmpu_pkg::REG_IMAGE_WIDTH:  width_q <= cfg_data;
			endcase
			col_q <= '0;
			rbc_q <= '0;
			bip_q <= '0;
		end else if (accept && step) begin
			if (restart) begin
				col_q <= '0;
				rbc_q <= '0;
				bip_q <= '0;
			end else begin
				col_q <= col_n;
				rbc_q <= rbc_inc[RL_W-1:0];
				bip_q <= bip_n;
			end
		end
	end

	// Bytes of a pixel in progress; always overwritten before use.
	always_ff @(posedge clk) begin
		if (accept && step) begin
			partial_q <= part_n;
		end
	end

	`ASSERT_ALWAYS(a_col_within_row, clk, arst_n, col_q <= w_eff, "column count beyond row width")

endmodule

// ===== rtl/bmpu_fifo.sv =====
// ----------------------------------------------------------------------------
// bmpu_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmpu_fifo #(
	parameter int DEPTH = bmpu_pkg::CMD_QUEUE_DEPTH  // power of two, two or more
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bmpu_pkg::cmd_t    push_cmd,
	output logic              full,
	input  logic              pop,
	output bmpu_pkg::cmd_t    head,
	output logic              head_valid
);

	localparam int AW = $clog2(DEPTH);

	bmpu_pkg::cmd_t   store_q [DEPTH];
	logic [AW:0]      wr_q;
	logic [AW:0]      rd_q;

	assign full       = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign head_valid = (wr_q != rd_q);
	assign head       = store_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + (AW + 1)'(1);
			end
			if (pop) begin
				rd_q <= rd_q + (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q[AW-1:0]] <= push_cmd;
		end
	end

	`ASSERT_ALWAYS(a_no_push_full, clk, arst_n, !(push && full), "push into a full queue")
	`ASSERT_ALWAYS(a_no_pop_empty, clk, arst_n, !(pop && !head_valid), "pop from an empty queue")

endmodule

// ===== rtl/bmpu_back.sv =====
// ----------------------------------------------------------------------------
// bmpu_back
// Executes queued commands: palette writes, direct colours, error results and
// palette look-ups, one pixel per cycle unless stalled, via a read stage and an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmpu_back #(
	parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bmpu_pkg::cmd_t                    head,
	input  logic                              head_valid,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bmpu_pkg::TDATA_W-1:0]      m_tdata,
	output logic                              m_tlast,
	output logic                              m_tuser
);

	localparam int PA_W = $clog2(PALETTE_DEPTH);

	logic [23:0]               mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0]  pal_valid_q;

	logic [2:0]                k_q;
	logic                      k_last;
	logic [5:0]                sh;
	logic [7:0]                shifted;
	logic [7:0]                pix_idx;
	logic                      rd_in_range;
	logic                      wr_in_range;
	logic [PA_W-1:0]           ra;
	logic [PA_W-1:0]           wa;
	logic                      is_wr;
	logic                      is_idx;
	logic                      wr_en;
	logic                      rd_en;
	logic                      issue;
	logic                      adv1;
	logic                      adv2;

	logic                               v1_q;
	logic [23:0]                        rd_data_s1;
	logic                               hit_s1;
	logic                               use_pal_s1;
	logic [23:0]                        rgb_s1;
	logic [bmpu_pkg::COL_OUT_W-1:0]     col_s1;
	logic                               row_end_s1;
	logic                               last_s1;
	logic                               err_s1;
	logic [23:0]                        color_s1;

	logic                               out_valid_q;
	logic [23:0]                        color_q;
	logic [bmpu_pkg::COL_OUT_W-1:0]     col_q;
	logic                               row_end_q;
	logic                               last_q;
	logic                               err_q;

	// Pixel k of a byte sits k pixel widths below the top bit.
	always_comb begin
		sh      = 6'(k_q) << head.log2bpp;
		shifted = head.data << sh;
		unique case (head.log2bpp)
			2'd0: pix_idx = {7'd0, shifted[7]};
			2'd1: pix_idx = {6'd0, shifted[7:6]};
			2'd2: pix_idx = {4'd0, shifted[7:4]};
			2'd3: pix_idx = shifted;
		endcase
	end

	assign rd_in_range = ({1'b0, pix_idx} < 9'(PALETTE_DEPTH));
	assign wr_in_range = ({1'b0, head.data} < 9'(PALETTE_DEPTH));
	assign ra          = pix_idx[PA_W-1:0];
	assign wa          = head.data[PA_W-1:0];

	assign is_wr  = head_valid && (head.kind == bmpu_pkg::CMD_PAL_WR);
	assign is_idx = (head.kind == bmpu_pkg::CMD_INDEXED);
	assign k_last = (k_q == head.count_m1);
	assign adv2   = !out_valid_q || m_tready;
	assign adv1   = !v1_q || adv2;
	assign issue  = head_valid && (head.kind != bmpu_pkg::CMD_PAL_WR) && adv1;
	assign pop    = is_wr || (issue && (!is_idx || k_last));
	assign wr_en  = is_wr && wr_in_range;
	assign rd_en  = issue && is_idx;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= head.rgb;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[ra];
			hit_s1     <= rd_in_range && pal_valid_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
			k_q         <= '0;
			v1_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				pal_valid_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				k_q <= k_last ? 3'd0 : k_q + 3'd1;
			end
			if (adv1) begin
				v1_q <= issue;
			end
			if (adv2) begin
				out_valid_q <= v1_q;
			end
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (issue) begin
			use_pal_s1 <= is_idx;
			rgb_s1     <= head.rgb;
			col_s1     <= is_idx ? head.col + bmpu_pkg::COL_OUT_W'(k_q) : head.col;
			last_s1    <= is_idx ? k_last : 1'b1;
			row_end_s1 <= is_idx ? (k_last && head.row_done) : head.row_done;
			err_s1     <= (head.kind == bmpu_pkg::CMD_ERROR);
		end
	end

	// Entries never written read as black.
	assign color_s1 = use_pal_s1 ? (hit_s1 ? rd_data_s1 : 24'd0) : rgb_s1;

	always_ff @(posedge clk) begin
		if (adv2 && v1_q) begin
			color_q   <= color_s1;
			col_q     <= col_s1;
			row_end_q <= row_end_s1;
			last_q    <= last_s1;
			err_q     <= err_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, row_end_q, col_q, color_q[7:0], color_q[15:8], color_q[23:16]};
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;

	`ASSERT_IMPLIES(a_k_within_count, clk, arst_n, head_valid && head.kind == bmpu_pkg::CMD_INDEXED, k_q <= head.count_m1, "pixel counter past end of byte")
	`ASSERT_IMPLIES(a_k_idle_zero, clk, arst_n, !(head_valid && head.kind == bmpu_pkg::CMD_INDEXED), k_q == 3'd0, "pixel counter left over between bytes")

endmodule

// ===== rtl/bmp_row_pixel_unpacker_top.sv =====
// ----------------------------------------------------------------------------
// bmp_row_pixel_unpacker_top
// Bitmap pixel array decoder: palette writes and row bytes in, RGB pixels out.
// ----------------------------------------------------------------------------
// The block takes one request per cycle on the slave stream whenever its
// four-entry command queue has room, so the input side runs at one request
// per clock. Each request is either a palette write or one byte of the padded
// pixel array. The back end produces one pixel per clock unless the receiver
// stalls it, so the sustained rate is set by the number of pixels in a byte;
// in the 16, 24 and 32-bit modes a multi-byte pixel appears after its last
// colour byte. A palette write occupies the back end and produces no pixel;
// padding bytes, bits after the end of a row and the alpha byte of 32-bit
// pixels produce nothing. The palette is a single-port-write, single-port-read
// memory with a registered read, which sets the look-up rate of one entry per
// cycle unless the output stalls; every entry reads as black until it is first
// written, with no clearing pass after reset. With the unsupported format
// selected, every pixel byte produces one result with the error flag set and
// zero colour, and the row position is left alone. Writing either
// configuration register restarts the current row but keeps the palette;
// write it only while no request is still being processed.
// ----------------------------------------------------------------------------
module bmp_row_pixel_unpacker_top #(
	parameter int MAX_WIDTH     = bmpu_pkg::MAX_WIDTH_DEFAULT,
	parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port
	input  logic                                 cfg_we,
	input  logic [bmpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bmpu_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Request stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// palette_index[7:0], palette_red[15:8], palette_green[23:16],
	// palette_blue[31:24], data_byte[39:32]
	input  logic [bmpu_pkg::TDATA_W-1:0]         s_axis_tdata,
	// action: 0 palette write, 1 pixel array byte
	input  logic                                 s_axis_tuser,
	// Pixel stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// red[7:0], green[15:8], blue[23:16], pixel_column[35:24], row_end[36],
	// zero fill[39:37]
	output logic [bmpu_pkg::TDATA_W-1:0]         m_axis_tdata,
	// last: final pixel produced by a request
	output logic                                 m_axis_tlast,
	// format_error
	output logic                                 m_axis_tuser
);

	bmpu_pkg::cmd_t  push_cmd;
	bmpu_pkg::cmd_t  head;
	logic            push;
	logic            full;
	logic            pop;
	logic            head_valid;

	// Front end: configuration, row bookkeeping and byte classification.
	bmpu_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.q_full    (full),
		.q_push    (push),
		.q_cmd     (push_cmd)
	);

	// Queue between the two halves so that each can stall on its own.
	bmpu_fifo #(
		.DEPTH (bmpu_pkg::CMD_QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// Back end: palette memory, per-pixel look-up and the output register.
	bmpu_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tlast    (m_axis_tlast),
		.m_tuser    (m_axis_tuser)
	);

endmodule

// ===== verif/bmp_row_pixel_unpacker_top_tb.sv =====
// ----------------------------------------------------------------------------
// bmp_row_pixel_unpacker_top_tb
// Self-checking bench for the bitmap row pixel unpacker. Palette writes and
// padded row bytes go in on the request stream; a behavioural decoder in the
// bench predicts every pixel, and each pixel leaving the block is compared
// field by field with the oldest prediction. Directed rows cover each pixel
// format but 2 and 4-bit, the padding rules and the register limits. Random
// rows then follow under several patterns of sender gaps and receiver stalls;
// their widths include the largest and oversized values, exercising the clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bmp_row_pixel_unpacker_top_tb;

	// Time the block may still be busy with requests that give no pixel, such
	// as palette writes and padding bytes, covering the queue and the pipeline with margin.
	localparam int SETTLE_CYCLES = 24;
	localparam int TAIL_CYCLES   = 40;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int ITEMS_PER_PHASE = 105;

	// One decoded pixel as the block should present it.
	typedef struct packed {
		logic [7:0]                     red;
		logic [7:0]                     green;
		logic [7:0]                     blue;
		logic [bmpu_pkg::COL_OUT_W-1:0] column;
		logic                           row_end;
		logic                           last;
		logic                           fmt_err;
	} pixel_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [bmpu_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [bmpu_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [bmpu_pkg::TDATA_W-1:0]     s_axis_tdata;
	logic                             s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [bmpu_pkg::TDATA_W-1:0]     m_axis_tdata;
	logic                             m_axis_tlast;
	logic                             m_axis_tuser;

	bmp_row_pixel_unpacker_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// ------------------------------------------------------------------------
	// Bench copy of the decoder state and of the two registers.
	// ------------------------------------------------------------------------
	logic [23:0]  palette_model [bmpu_pkg::PALETTE_DEPTH_DEFAULT];
	logic [2:0]   cur_format;
	logic [12:0]  cur_width;
	int unsigned  row_bytes_seen;
	int unsigned  col_count;
	int unsigned  pix_acc;
	int unsigned  pix_bytes;

	pixel_t       expected_pixels [$];

	int           src_idle_pct  = 0;
	int           sink_stall_pct = 0;
	int           mismatch_count = 0;
	int           counted_items  = 0;
	int unsigned  cycle_count    = 0;

	// Capture of the output side at a rising edge, checked at the next falling
	// edge so that predictions made at the same edge are always in place.
	logic                         seen_valid;
	logic [bmpu_pkg::TDATA_W-1:0] seen_data;
	logic                         seen_last;
	logic                         seen_err;
	pixel_t                       want;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost pixel ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// The receiver stalls at random with the percentage of the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Decoder helpers shared by the prediction and the stimulus generator.
	// ------------------------------------------------------------------------
	function automatic int unsigned clamp_width(logic [12:0] w);
		if (w == 0)
			return 1;
		if (w > bmpu_pkg::MAX_WIDTH_DEFAULT)
			return bmpu_pkg::MAX_WIDTH_DEFAULT;
		return 32'(w);
	endfunction

	function automatic int unsigned bits_for_format(logic [2:0] fmt);
		case (fmt)
			bmpu_pkg::FMT_1BPP:  return 1;
			bmpu_pkg::FMT_2BPP:  return 2;
			bmpu_pkg::FMT_4BPP:  return 4;
			bmpu_pkg::FMT_8BPP:  return 8;
			bmpu_pkg::FMT_16BPP: return 16;
			bmpu_pkg::FMT_24BPP: return 24;
			default:             return 32;
		endcase
	endfunction

	// Bytes in one stored row, rounded up to a multiple of four.
	function automatic int unsigned padded_row_bytes(logic [2:0] fmt, int unsigned w);
		int unsigned len;
		len = (w * bits_for_format(fmt) + 7) / 8;
		return (len + 3) & ~32'd3;
	endfunction

	function automatic void restart_row();
		row_bytes_seen = 0;
		col_count      = 0;
		pix_acc        = 0;
		pix_bytes      = 0;
	endfunction

	// Builds the next pixel of the row and moves the column on.
	function automatic pixel_t make_pixel(logic [23:0] rgb, int unsigned w);
		pixel_t px;
		px.red     = rgb[23:16];
		px.green   = rgb[15:8];
		px.blue    = rgb[7:0];
		px.column  = col_count[bmpu_pkg::COL_OUT_W-1:0];
		px.row_end = (col_count + 1 == w);
		px.last    = 1'b0;
		px.fmt_err = 1'b0;
		col_count++;
		return px;
	endfunction

	// Works out the pixels one accepted request gives and queues them; returns
	// how many there are.
	function automatic int predict_pixels(logic act, logic [7:0] idx, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic [7:0] dbyte);
		pixel_t      batch [8];
		pixel_t      px;
		int unsigned w;
		int unsigned bpp;
		int unsigned row_len;
		int unsigned pidx;
		logic [23:0] rgb;
		int          n;
		n = 0;
		if (act == bmpu_pkg::ACT_PALETTE) begin
			palette_model[idx] = {r, g, b};
			return 0;
		end
		// The unsupported format flags each byte and leaves the row untouched.
		if (cur_format == bmpu_pkg::FMT_UNSUP) begin
			px         = '0;
			px.last    = 1'b1;
			px.fmt_err = 1'b1;
			expected_pixels.push_back(px);
			return 1;
		end
		w       = clamp_width(cur_width);
		bpp     = bits_for_format(cur_format);
		row_len = padded_row_bytes(cur_format, w);
		if (bpp <= 8) begin
			// Indexed: first pixel in the top bits; bits past the row end are dropped.
			for (int k = 0; k < 8 / bpp && col_count < w; k++) begin
				pidx     = (int'(dbyte) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
				batch[n] = make_pixel(palette_model[pidx], w);
				n++;
			end
		end else if (col_count < w) begin
			// Direct colour: collect bytes, lowest first; a fourth byte is skipped.
			if (pix_bytes < 3)
				pix_acc = pix_acc | (int'(dbyte) << (8 * pix_bytes));
			pix_bytes++;
			if (bpp == 16 && pix_bytes == 2) begin
				rgb = {pix_acc[14:10], 3'b000, pix_acc[9:5], 3'b000, pix_acc[4:0], 3'b000};
				batch[n] = make_pixel(rgb, w);
				n++;
			end else if (bpp > 16 && pix_bytes == 3) begin
				batch[n] = make_pixel(pix_acc[23:0], w);
				n++;
			end
			if (pix_bytes >= bpp / 8) begin
				pix_bytes = 0;
				pix_acc   = 0;
			end
		end
		row_bytes_seen++;
		if (row_bytes_seen >= row_len)
			restart_row();
		for (int i = 0; i < n; i++) begin
			px      = batch[i];
			px.last = (i == n - 1);
			expected_pixels.push_back(px);
		end
		return n;
	endfunction

	// ------------------------------------------------------------------------
	// Output checking.
	// ------------------------------------------------------------------------
	task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatch_count++;
		end
	endtask

	always begin
		@(posedge clk);
		seen_valid = arst_n && m_axis_tvalid && m_axis_tready;
		seen_data  = m_axis_tdata;
		seen_last  = m_axis_tlast;
		seen_err   = m_axis_tuser;
		@(negedge clk);
		if (seen_valid) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel with no prediction waiting: tdata %h", seen_data);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("red", want.red, seen_data[7:0]);
				check_field("green", want.green, seen_data[15:8]);
				check_field("blue", want.blue, seen_data[23:16]);
				check_field("pixel_column", want.column, seen_data[35:24]);
				check_field("row_end", want.row_end, seen_data[36]);
				check_field("last", want.last, seen_last);
				check_field("format_error", want.fmt_err, seen_err);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side.
	// ------------------------------------------------------------------------

	// Sends one request, idling first at the rate of the current phase. Valid
	// stays high after the handshake, so back-to-back requests need no gap.
	task automatic send_request(logic act, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] dbyte);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {dbyte, b, g, r, idx};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		void'(predict_pixels(act, idx, r, g, b, dbyte));
		counted_items++;
	endtask

	// Pixel byte: the palette fields carry noise, which the block must ignore.
	task automatic send_pixel_byte(logic [7:0] dbyte);
		send_request(bmpu_pkg::ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), dbyte);
	endtask

	// Palette write: the data byte carries noise.
	task automatic send_palette_entry(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		send_request(bmpu_pkg::ACT_PALETTE, idx, r, g, b, 8'($urandom));
	endtask

	// A random row byte, now and then preceded by a random palette write so
	// that palette traffic also lands in the middle of multi-byte pixels.
	task automatic send_row_byte();
		if ($urandom_range(9) == 0)
			send_palette_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send_pixel_byte(8'($urandom));
	endtask

	// Holds the sender off until every predicted pixel has arrived, then lets
	// the block finish any request that gives no pixel.
	task automatic wait_for_pixels();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with the block idle; each one restarts the row.
	task automatic write_reg(logic [bmpu_pkg::CFG_INDEX_W-1:0] idx,
			logic [bmpu_pkg::CFG_DATA_W-1:0] val);
		wait_for_pixels();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bmpu_pkg::REG_PIXEL_FORMAT)
			cur_format = val[2:0];
		else
			cur_width = val;
		restart_row();
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Reset leaves 24-bit mode and a width of one: three colour bytes and one
	// padding byte make a row.
	task automatic test_reset_defaults();
		send_pixel_byte(8'h11);
		send_pixel_byte(8'h22);
		send_pixel_byte(8'h33);
		send_pixel_byte(8'hFF);
		wait_for_pixels();
	endtask

	// Palette at both ends of its index range, 1-bit rows with trailing bits
	// and padding, and 8-bit look-ups including an entry never written.
	task automatic test_palette_indexed();
		send_palette_entry(8'd0, 8'h12, 8'h34, 8'h56);
		send_palette_entry(8'd1, 8'hFF, 8'hFF, 8'hFF);
		send_palette_entry(8'd255, 8'hA0, 8'h0B, 8'hC5);
		write_reg(bmpu_pkg::REG_PIXEL_FORMAT, {10'd0, bmpu_pkg::FMT_1BPP});
		write_reg(bmpu_pkg::REG_IMAGE_WIDTH, 13'd10);
		send_pixel_byte(8'hA5);
		send_pixel_byte(8'hC0);  // two pixels, the remaining six bits are unused
		send_pixel_byte(8'h00);
		send_pixel_byte(8'hFF);
		// Sender pauses here until the whole row has been seen.
		wait_for_pixels();
		write_reg(bmpu_pkg::REG_PIXEL_FORMAT, {10'd0, bmpu_pkg::FMT_8BPP});
		write_reg(bmpu_pkg::REG_IMAGE_WIDTH, 13'd3);
		send_pixel_byte(8'hFF);
		send_pixel_byte(8'h01);
		send_pixel_byte(8'h02);  // entry two was never written and reads as black
	endtask

	// 5-5-5 with blue in the low bits, then a 32-bit pixel whose fourth byte
	// is skipped.
	task automatic test_direct_formats();
		write_reg(bmpu_pkg::REG_PIXEL_FORMAT, {10'd0, bmpu_pkg::FMT_16BPP});
		write_reg(bmpu_pkg::REG_IMAGE_WIDTH, 13'd2);
		send_pixel_byte(8'h1F);
		send_pixel_byte(8'h00);
		send_pixel_byte(8'hFF);
		send_pixel_byte(8'h7F);
		write_reg(bmpu_pkg::REG_PIXEL_FORMAT, {10'd0, bmpu_pkg::FMT_32BPP});
		send_pixel_byte(8'h01);
		send_pixel_byte(8'h02);
		send_pixel_byte(8'h03);
		send_pixel_byte(8'hFF);
	endtask

	// Unsupported format: every byte flags an error, palette writes stay silent.
	task automatic test_unsupported_format();
		write_reg(bmpu_pkg::REG_PIXEL_FORMAT, {10'h3FF, bmpu_pkg::FMT_UNSUP});
		send_pixel_byte(8'hFF);
		send_palette_entry(8'd2, 8'h55, 8'hAA, 8'h5A);
		send_pixel_byte(8'h00);
	endtask

	// A width of zero behaves as one pixel per row.
	task automatic test_width_limits();
		write_reg(bmpu_pkg::REG_PIXEL_FORMAT, {10'd0, bmpu_pkg::FMT_24BPP});
		write_reg(bmpu_pkg::REG_IMAGE_WIDTH, 13'd0);
		send_pixel_byte(8'h80);
		send_pixel_byte(8'h7F);
		send_pixel_byte(8'hFF);
	endtask

	// One random setting: mostly whole rows, with cut-off rows and error bytes
	// as noise. Large widths only ever get a short partial row.
	task automatic run_random_segment();
		logic [2:0]  fmt;
		logic [12:0] w;
		int unsigned row_len;
		int unsigned rows;
		int unsigned cut;
		fmt = ($urandom_range(15) == 0) ? bmpu_pkg::FMT_UNSUP : 3'($urandom_range(6));
		case ($urandom_range(11))
			0:       w = 13'd0;
			1:       w = 13'd4096;
			2:       w = 13'h1FFF;
			3:       w = 13'($urandom);
			default: w = 13'($urandom_range(1, 24));
		endcase
		if ($urandom_range(1)) begin
			write_reg(bmpu_pkg::REG_PIXEL_FORMAT, {10'($urandom), fmt});
			write_reg(bmpu_pkg::REG_IMAGE_WIDTH, w);
		end else begin
			write_reg(bmpu_pkg::REG_IMAGE_WIDTH, w);
			write_reg(bmpu_pkg::REG_PIXEL_FORMAT, {10'($urandom), fmt});
		end
		if (fmt == bmpu_pkg::FMT_UNSUP) begin
			repeat ($urandom_range(1, 6)) send_row_byte();
			return;
		end
		row_len = padded_row_bytes(fmt, clamp_width(w));
		rows    = (row_len > 48) ? 0 : $urandom_range(1, 3);
		repeat (rows)
			repeat (row_len) send_row_byte();
		if (rows == 0 || $urandom_range(3) == 0) begin
			cut = (row_len > 12) ? 12 : row_len - 1;
			repeat ($urandom_range(1, cut)) send_row_byte();
		end
	endtask

	// Four phases of idling: none, sender gaps, receiver stalls, then both.
	task automatic test_random_traffic();
		int src_pct [4]  = '{0, 68, 0, 25};
		int sink_pct [4] = '{0, 0, 68, 25};
		for (int p = 0; p < 4; p++) begin
			wait_for_pixels();
			src_idle_pct   = src_pct[p];
			sink_stall_pct = sink_pct[p];
			counted_items  = 0;
			while (counted_items < ITEMS_PER_PHASE)
				run_random_segment();
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence of the run.
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = bmpu_pkg::REG_PIXEL_FORMAT;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = bmpu_pkg::ACT_PALETTE;
		for (int i = 0; i < bmpu_pkg::PALETTE_DEPTH_DEFAULT; i++)
			palette_model[i] = '0;
		cur_format = bmpu_pkg::FMT_24BPP;
		cur_width  = 13'd1;
		restart_row();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_palette_indexed();
		test_direct_formats();
		test_unsupported_format();
		test_width_limits();
		test_random_traffic();

		// Drain everything still predicted, then allow the pipeline to empty.
		wait_for_pixels();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
